[design/flow_pulse_level_estimator_macros.svh]
// assertion macros for the flow pulse level estimator
`ifndef FLOW_PULSE_LEVEL_ESTIMATOR_MACROS_SVH
`define FLOW_PULSE_LEVEL_ESTIMATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication on the block clock, off during reset
`define FPLE_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("fple: same-cycle check failed");
// next-cycle implication on the block clock, off during reset
`define FPLE_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("fple: next-cycle check failed");
`else
`define FPLE_ASSERT_SAME(label, pre, post)
`define FPLE_ASSERT_NEXT(label, pre, post)
`endif
`endif

[design/fple_pkg.sv]
// shared types, constants and microcode table of the flow pulse level estimator
package fple_pkg;

    // field and state widths
    localparam int AMT_W         = 26;
    localparam int CUR_W         = 32;
    localparam int CNT_W         = 16;
    localparam int RATE_W        = 24;
    localparam int RES_W         = 27;
    localparam int FRAC_W        = 17;
    localparam int Q_W           = 26;
    localparam int IN_TDATA_W    = 32;
    localparam int OUT_TDATA_W   = 96;
    localparam int ELAPSED_BITS_DEF = 24;

    // arithmetic constants
    localparam int UL_PER_PULSE    = 135;
    localparam int UL_PER_ML       = 1000;
    localparam int RESET_AMOUNT_UL = 200 * UL_PER_ML;
    localparam int FRAC_FULL       = 65536;
    localparam int RES_MAX         = (1 << 26) - 1;

    // item kinds carried on the input tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_REFILL = 1'b1;

    // step counter
    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc S_IDLE      = 5'd0;
    localparam t_pc S_BRANCH    = 5'd1;
    localparam t_pc S_RATE      = 5'd2;
    localparam t_pc S_SUB       = 5'd3;
    localparam t_pc S_PREP      = 5'd4;
    localparam t_pc S_DIV_FRAC  = 5'd5;
    localparam t_pc S_WAIT_FRAC = 5'd6;
    localparam t_pc S_DIV_AVG   = 5'd7;
    localparam t_pc S_WAIT_AVG  = 5'd8;
    localparam t_pc S_DIV_TTE   = 5'd9;
    localparam t_pc S_WAIT_TTE  = 5'd10;
    localparam t_pc S_CAP_TTE   = 5'd11;
    localparam t_pc S_EMIT      = 5'd12;
    localparam t_pc S_RETURN    = 5'd13;
    localparam t_pc S_EMPTY     = 5'd14;
    localparam t_pc S_EMPTY_RET = 5'd15;
    localparam t_pc S_REFILL    = 5'd16;

    // datapath actions
    typedef enum logic [3:0] {
        A_NONE,
        A_ACCEPT,
        A_RATE,
        A_SUB,
        A_PREP,
        A_START_FRAC,
        A_CAP_FRAC_AVG,
        A_CAP_AVG_TTE,
        A_CAP_TTE,
        A_EMIT,
        A_EMIT_EMPTY,
        A_REFILL
    } t_act;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_REFILL,
        C_EMPTY,
        C_DIV_BUSY,
        C_OUT_FULL
    } t_cond;

    // one control word
    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_pc   target;
    } t_ctl;

    // status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic is_refill;
        logic is_empty;
        logic div_busy;
        logic out_full;
    } t_flags;

    // microprogram
    function automatic t_ctl fple_ucode(input t_pc pc);
        t_ctl w;
        unique case (pc)
            S_IDLE:      w = '{act: A_ACCEPT,       cond: C_NO_ITEM,  target: S_IDLE};
            S_BRANCH:    w = '{act: A_NONE,         cond: C_REFILL,   target: S_REFILL};
            S_RATE:      w = '{act: A_RATE,         cond: C_NEVER,    target: S_IDLE};
            S_SUB:       w = '{act: A_SUB,          cond: C_NEVER,    target: S_IDLE};
            S_PREP:      w = '{act: A_PREP,         cond: C_EMPTY,    target: S_EMPTY};
            S_DIV_FRAC:  w = '{act: A_START_FRAC,   cond: C_NEVER,    target: S_IDLE};
            S_WAIT_FRAC: w = '{act: A_NONE,         cond: C_DIV_BUSY, target: S_WAIT_FRAC};
            S_DIV_AVG:   w = '{act: A_CAP_FRAC_AVG, cond: C_NEVER,    target: S_IDLE};
            S_WAIT_AVG:  w = '{act: A_NONE,         cond: C_DIV_BUSY, target: S_WAIT_AVG};
            S_DIV_TTE:   w = '{act: A_CAP_AVG_TTE,  cond: C_NEVER,    target: S_IDLE};
            S_WAIT_TTE:  w = '{act: A_NONE,         cond: C_DIV_BUSY, target: S_WAIT_TTE};
            S_CAP_TTE:   w = '{act: A_CAP_TTE,      cond: C_NEVER,    target: S_IDLE};
            S_EMIT:      w = '{act: A_EMIT,         cond: C_OUT_FULL, target: S_EMIT};
            S_RETURN:    w = '{act: A_NONE,         cond: C_ALWAYS,   target: S_IDLE};
            S_EMPTY:     w = '{act: A_EMIT_EMPTY,   cond: C_OUT_FULL, target: S_EMPTY};
            S_EMPTY_RET: w = '{act: A_NONE,         cond: C_ALWAYS,   target: S_IDLE};
            S_REFILL:    w = '{act: A_REFILL,       cond: C_ALWAYS,   target: S_IDLE};
            default:     w = '{act: A_NONE,         cond: C_ALWAYS,   target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

[design/flow_pulse_level_estimator.sv]
// top level of the flow pulse level estimator: datapath, handshakes and checks
// Reservoir level estimator fed with flow-meter pulse counts. A sample item
// (tuser 0) is handled by a short microprogram that walks the datapath and
// runs one serial divider three times (fraction, average rate, time to
// empty), each giving a 26-bit quotient, and waits for each to be done. A
// sample that leaves the reservoir empty skips the divisions. A refill item
// (tuser 1) gives no result. A finished result sits in the output register, so
// the next item is taken while it waits; a new result waits for that register
// to empty.
`include "flow_pulse_level_estimator_macros.svh"
module flow_pulse_level_estimator #(
    parameter int ELAPSED_BITS = fple_pkg::ELAPSED_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // pulse_count [15:0], refill_ml [31:16]
    input  logic [fple_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // op [0]
    input  logic                               i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // current_rate_ul_s [23:0], average_rate_ul_s [50:24],
    // remaining_fraction [67:51], time_to_empty_s [94:68], zero [95]
    output logic [fple_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // empty_flag [0]
    output logic                               o_m_tuser
);

    localparam int AMT_W  = fple_pkg::AMT_W;
    localparam int CUR_W  = fple_pkg::CUR_W;
    localparam int CNT_W  = fple_pkg::CNT_W;
    localparam int RATE_W = fple_pkg::RATE_W;
    localparam int RES_W  = fple_pkg::RES_W;
    localparam int FRAC_W = fple_pkg::FRAC_W;
    localparam int Q_W    = fple_pkg::Q_W;
    localparam int NW     = AMT_W + ELAPSED_BITS;
    localparam int DVW    = (ELAPSED_BITS > AMT_W) ? ELAPSED_BITS : AMT_W;

    fple_pkg::t_ctl   w_ctl;
    fple_pkg::t_flags w_flags;

    // item registers
    logic                    r_op;
    logic [CNT_W-1:0]        r_pulses;
    logic [CNT_W-1:0]        r_refill;

    // state
    logic [AMT_W-1:0]        r_init;
    logic [CUR_W-1:0]        r_cur;
    logic [ELAPSED_BITS-1:0] r_secs;

    // working registers
    logic [RATE_W-1:0]       r_rate;
    logic [AMT_W-1:0]        r_used;
    logic [NW-1:0]           r_prod;
    logic [FRAC_W-1:0]       r_frac;
    logic [RES_W-1:0]        r_avg;
    logic [RES_W-1:0]        r_tte;

    // output register
    logic                    r_out_valid;
    logic [RATE_W-1:0]       r_o_rate;
    logic [RES_W-1:0]        r_o_avg;
    logic [FRAC_W-1:0]       r_o_frac;
    logic [RES_W-1:0]        r_o_tte;
    logic                    r_o_empty;

    // divider hookup
    logic                    w_div_start;
    logic [NW-1:0]           w_dividend;
    logic [DVW-1:0]          w_divisor;
    logic                    w_div_busy;
    logic                    w_div_ovf;
    logic [Q_W-1:0]          w_quo;

    logic                    w_fire;
    logic                    w_emit;
    logic [CUR_W:0]          w_diff;
    logic                    w_secs_zero;

    // sequencer
    assign w_flags = '{
        in_valid:  i_s_tvalid,
        is_refill: (r_op == fple_pkg::OP_REFILL),
        is_empty:  r_cur[CUR_W-1] || (r_cur == '0),
        div_busy:  w_div_busy,
        out_full:  r_out_valid
    };

    fple_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctl   (w_ctl)
    );

    // input handshake
    assign o_s_tready = (w_ctl.act == fple_pkg::A_ACCEPT);
    assign w_fire     = i_s_tvalid && o_s_tready;
    assign w_emit     = ((w_ctl.act == fple_pkg::A_EMIT) ||
                         (w_ctl.act == fple_pkg::A_EMIT_EMPTY)) && !r_out_valid;

    // amount after consumption, one bit wider to see underflow
    assign w_diff      = {r_cur[CUR_W-1], r_cur} - {{(CUR_W+1-RATE_W){1'b0}}, r_rate};
    assign w_secs_zero = (r_secs == '0);

    // divider operand select
    always_comb begin
        w_div_start = 1'b0;
        w_dividend  = '0;
        w_divisor   = '0;
        unique case (w_ctl.act)
            fple_pkg::A_START_FRAC: begin
                w_div_start = 1'b1;
                w_dividend  = NW'({r_cur[AMT_W-1:0], 16'h0000});
                w_divisor   = DVW'(r_init);
            end
            fple_pkg::A_CAP_FRAC_AVG: begin
                w_div_start = 1'b1;
                w_dividend  = NW'(r_used);
                w_divisor   = DVW'(r_secs);
            end
            fple_pkg::A_CAP_AVG_TTE: begin
                w_div_start = 1'b1;
                w_dividend  = r_prod;
                w_divisor   = DVW'(r_used);
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    fple_div #(
        .NW  (NW),
        .DVW (DVW),
        .QW  (Q_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_ovf      (w_div_ovf),
        .o_quotient (w_quo)
    );

    // item capture
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_op     <= i_s_tuser;
            r_pulses <= i_s_tdata[CNT_W-1:0];
            r_refill <= i_s_tdata[2*CNT_W-1:CNT_W];
        end
    end

    // reservoir state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= AMT_W'(fple_pkg::RESET_AMOUNT_UL);
            r_cur  <= CUR_W'(fple_pkg::RESET_AMOUNT_UL);
            r_secs <= '0;
        end else begin
            unique case (w_ctl.act)
                fple_pkg::A_REFILL: begin
                    r_init <= AMT_W'(r_refill) * AMT_W'(fple_pkg::UL_PER_ML);
                    r_cur  <= CUR_W'(AMT_W'(r_refill) * AMT_W'(fple_pkg::UL_PER_ML));
                    r_secs <= '0;
                end
                fple_pkg::A_RATE: begin
                    if (r_secs != {ELAPSED_BITS{1'b1}}) begin
                        r_secs <= r_secs + 1'b1;
                    end
                end
                fple_pkg::A_SUB: begin
                    if (w_diff[CUR_W] != w_diff[CUR_W-1]) begin
                        r_cur <= {1'b1, {(CUR_W-1){1'b0}}};
                    end else begin
                        r_cur <= w_diff[CUR_W-1:0];
                    end
                end
                default: begin
                    r_cur <= r_cur;
                end
            endcase
        end
    end

    // working values and quotient capture with the special cases
    always_ff @(posedge i_clk) begin
        unique case (w_ctl.act)
            fple_pkg::A_RATE: begin
                r_rate <= RATE_W'(r_pulses) * RATE_W'(fple_pkg::UL_PER_PULSE);
            end
            fple_pkg::A_PREP: begin
                r_used <= ({{(CUR_W-AMT_W){1'b0}}, r_init} > r_cur) ?
                          (r_init - r_cur[AMT_W-1:0]) : '0;
                r_prod <= NW'(r_cur[AMT_W-1:0]) * NW'(r_secs);
            end
            fple_pkg::A_CAP_FRAC_AVG: begin
                if ((r_init == '0) || w_div_ovf ||
                    (w_quo > Q_W'(fple_pkg::FRAC_FULL))) begin
                    r_frac <= FRAC_W'(fple_pkg::FRAC_FULL);
                end else begin
                    r_frac <= w_quo[FRAC_W-1:0];
                end
            end
            fple_pkg::A_CAP_AVG_TTE: begin
                if (w_secs_zero) begin
                    r_avg <= '1;
                end else if (w_div_ovf) begin
                    r_avg <= RES_W'(fple_pkg::RES_MAX);
                end else begin
                    r_avg <= {1'b0, w_quo};
                end
            end
            fple_pkg::A_CAP_TTE: begin
                if (w_secs_zero || (r_used == '0)) begin
                    r_tte <= '1;
                end else if (w_div_ovf) begin
                    r_tte <= RES_W'(fple_pkg::RES_MAX);
                end else begin
                    r_tte <= {1'b0, w_quo};
                end
            end
            default: begin
                r_rate <= r_rate;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            if (w_ctl.act == fple_pkg::A_EMIT_EMPTY) begin
                r_o_rate  <= '0;
                r_o_avg   <= '0;
                r_o_frac  <= '0;
                r_o_tte   <= '0;
                r_o_empty <= 1'b1;
            end else begin
                r_o_rate  <= r_rate;
                r_o_avg   <= r_avg;
                r_o_frac  <= r_frac;
                r_o_tte   <= r_tte;
                r_o_empty <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_o_tte, r_o_frac, r_o_avg, r_o_rate};
    assign o_m_tuser  = r_o_empty;

    // checks
    `FPLE_ASSERT_SAME(a_cur_within_init, !r_cur[CUR_W-1], r_cur <= CUR_W'(r_init))
    `FPLE_ASSERT_SAME(a_div_busy_in_wait, w_div_busy, w_ctl.cond == fple_pkg::C_DIV_BUSY)
    `FPLE_ASSERT_SAME(a_secs_set_on_result, w_emit && !r_o_empty, !w_secs_zero)
    `FPLE_ASSERT_NEXT(a_accept_then_branch, w_fire, w_ctl.cond == fple_pkg::C_REFILL)

endmodule

[design/fple_div.sv]
// serial restoring divider, one quotient bit per cycle, with overflow detect
module fple_div #(
    parameter int NW  = fple_pkg::AMT_W + fple_pkg::ELAPSED_BITS_DEF,
    parameter int DVW = (fple_pkg::ELAPSED_BITS_DEF > fple_pkg::AMT_W) ?
                        fple_pkg::ELAPSED_BITS_DEF : fple_pkg::AMT_W,
    parameter int QW  = fple_pkg::Q_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [NW-1:0]  i_dividend,
    input  logic [DVW-1:0] i_divisor,
    output logic           o_busy,
    output logic           o_ovf,
    output logic [QW-1:0]  o_quotient
);

    localparam int CW = $clog2(QW + 1);

    logic [DVW-1:0] r_rem;
    logic [DVW-1:0] r_dvs;
    logic [QW-1:0]  r_quo;
    logic [CW-1:0]  r_cnt;
    logic           r_ovf;

    logic [DVW+1:0] w_trial;
    logic [DVW:0]   w_shifted;

    // trial subtraction of the divisor from the shifted remainder
    always_comb begin
        w_shifted = {r_rem, r_quo[QW-1]};
        w_trial   = {1'b0, w_shifted} - {2'b00, r_dvs};
    end

    // iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(QW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DVW'(i_dividend[NW-1:QW]);
            r_quo <= i_dividend[QW-1:0];
            r_dvs <= i_divisor;
            r_ovf <= (DVW'(i_dividend[NW-1:QW]) >= i_divisor);
        end else if (r_cnt != '0) begin
            if (!w_trial[DVW+1]) begin
                r_rem <= w_trial[DVW-1:0];
                r_quo <= {r_quo[QW-2:0], 1'b1};
            end else begin
                r_rem <= w_shifted[DVW-1:0];
                r_quo <= {r_quo[QW-2:0], 1'b0};
            end
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_ovf      = r_ovf;
    assign o_quotient = r_quo;

endmodule

[design/fple_seq.sv]
// microcode sequencer: step counter, control word fetch and conditional jumps
module fple_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fple_pkg::t_flags i_flags,
    output fple_pkg::t_ctl   o_ctl
);

    fple_pkg::t_pc  r_pc;
    fple_pkg::t_pc  n_pc;
    fple_pkg::t_ctl w_ctl;
    logic           w_take;

    // fetch and condition select
    always_comb begin
        w_ctl = fple_pkg::fple_ucode(r_pc);
        unique case (w_ctl.cond)
            fple_pkg::C_NEVER:    w_take = 1'b0;
            fple_pkg::C_ALWAYS:   w_take = 1'b1;
            fple_pkg::C_NO_ITEM:  w_take = !i_flags.in_valid;
            fple_pkg::C_REFILL:   w_take = i_flags.is_refill;
            fple_pkg::C_EMPTY:    w_take = i_flags.is_empty;
            fple_pkg::C_DIV_BUSY: w_take = i_flags.div_busy;
            fple_pkg::C_OUT_FULL: w_take = i_flags.out_full;
            default:              w_take = 1'b1;
        endcase
        n_pc = w_take ? w_ctl.target : r_pc + 1'b1;
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= fple_pkg::S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl = w_ctl;

endmodule
